// ----- rtl/mfep_pkg.sv -----
// Package for the MIDI file event parser: payload structs, phase codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package mfep_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] track_index;
        logic [31:0] delta_time;
        logic [31:0] absolute_time;
        logic [7:0]  message_byte;
        logic        message_first;
        logic        message_last;
        logic [1:0]  file_format;
        logic [15:0] track_count;
        logic [15:0] division;
        logic [1:0]  error_code;
    } out_item_t;

    localparam int MaxRes = 3;

    // A byte yields up to three result rows.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
        out_item_t  r2;
    } res_group_t;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_MSG = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    localparam logic [1:0] ERR_MTHD = 2'd0;
    localparam logic [1:0] ERR_HLEN = 2'd1;
    localparam logic [1:0] ERR_FMT  = 2'd2;
    localparam logic [1:0] ERR_MTRK = 2'd3;

    localparam logic [3:0] PH_SIG_HDR   = 4'd0;
    localparam logic [3:0] PH_HDR_LEN   = 4'd1;
    localparam logic [3:0] PH_FMT       = 4'd2;
    localparam logic [3:0] PH_NTRK      = 4'd3;
    localparam logic [3:0] PH_DIV       = 4'd4;
    localparam logic [3:0] PH_SIG_TRK   = 4'd5;
    localparam logic [3:0] PH_TRK_LEN   = 4'd6;
    localparam logic [3:0] PH_DELTA     = 4'd7;
    localparam logic [3:0] PH_STATUS    = 4'd8;
    localparam logic [3:0] PH_META_TYPE = 4'd9;
    localparam logic [3:0] PH_BODY_LEN  = 4'd10;
    localparam logic [3:0] PH_BODY      = 4'd11;
    localparam logic [3:0] PH_CHAN      = 4'd12;
    localparam logic [3:0] PH_DONE      = 4'd13;
    localparam logic [3:0] PH_ERROR     = 4'd14;

    localparam logic [31:0] SIG_MTHD = 32'h4D546864;
    localparam logic [31:0] SIG_MTRK = 32'h4D54726B;

    localparam logic [7:0] ST_META  = 8'hFF;
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_ESC   = 8'hF7;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: data_count = 2'd2;
            4'hC, 4'hD:                   data_count = 2'd1;
            default:                      data_count = 2'd0;
        endcase
    endfunction

endpackage

// ----- rtl/mfep_core.sv -----
// Parser state and per-byte decode: one byte in, up to three result rows out.
// Depends on mfep_pkg.
`timescale 1ns / 1ps
module mfep_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  mfep_pkg::in_item_t   in_item,
    output mfep_pkg::res_group_t res
);
    import mfep_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] facc_reg, facc_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [15:0] ntrk_reg, ntrk_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] tcnt_reg, tcnt_next;
    logic [31:0] tleft_reg, tleft_next;
    logic [31:0] dacc_reg, dacc_next;
    logic [31:0] tacc_reg, tacc_next;
    logic [7:0]  rs_reg, rs_next;
    logic [7:0]  cs_reg, cs_next;
    logic [7:0]  mt_reg, mt_next;
    logic [31:0] bleft_reg, bleft_next;

    out_item_t rows [MaxRes];
    logic [1:0] n;

    function automatic out_item_t msg_row(input logic [15:0] ti, input logic [31:0] dt,
                                          input logic [31:0] at, input logic [7:0] b,
                                          input logic f, input logic l);
        out_item_t r;
        r = '0;
        r.kind = KIND_MSG;
        r.track_index = ti;
        r.delta_time = dt;
        r.absolute_time = at;
        r.message_byte = b;
        r.message_first = f;
        r.message_last = l;
        msg_row = r;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic [2:0]  need;
        logic [31:0] v;
        logic [31:0] bl;
        logic [1:0]  cnt;
        logic [7:0]  st;
        logic        redo;
        logic        ended;

        b = in_item.data_byte;
        phase_next = phase_reg; fcnt_next = fcnt_reg; facc_next = facc_reg;
        fmt_next = fmt_reg; ntrk_next = ntrk_reg; div_next = div_reg;
        tcnt_next = tcnt_reg; tleft_next = tleft_reg; dacc_next = dacc_reg;
        tacc_next = tacc_reg; rs_next = rs_reg; cs_next = cs_reg;
        mt_next = mt_reg; bleft_next = bleft_reg;
        if (in_item.start_of_file) begin
            phase_next = PH_SIG_HDR; fcnt_next = '0; facc_next = '0; fmt_next = '0;
            ntrk_next = '0; div_next = '0; tcnt_next = '0; tleft_next = '0;
            dacc_next = '0; tacc_next = '0; rs_next = '0; cs_next = '0;
            mt_next = '0; bleft_next = '0;
        end
        rows[0] = '0; rows[1] = '0; rows[2] = '0;
        n = 2'd0;
        v = '0; bl = '0; cnt = '0; st = '0; redo = 1'b0; ended = 1'b0;

        case (phase_next)
            PH_SIG_HDR, PH_HDR_LEN, PH_SIG_TRK, PH_TRK_LEN: need = 3'd4;
            PH_FMT, PH_NTRK, PH_DIV:                        need = 3'd2;
            default:                                        need = 3'd0;
        endcase

        if (need != 3'd0) begin
            v = {facc_next[23:0], b};
            if (fcnt_next + 3'd1 < need) begin
                facc_next = v;
                fcnt_next = fcnt_next + 3'd1;
            end else begin
                fcnt_next = '0;
                facc_next = '0;
                case (phase_next)
                    PH_SIG_HDR: begin
                        if (v != SIG_MTHD) begin
                            rows[0].kind = KIND_ERR; rows[0].error_code = ERR_MTHD;
                            n = 2'd1; phase_next = PH_ERROR;
                        end else phase_next = PH_HDR_LEN;
                    end
                    PH_HDR_LEN: begin
                        if (v != 32'd6) begin
                            rows[0].kind = KIND_ERR; rows[0].error_code = ERR_HLEN;
                            n = 2'd1; phase_next = PH_ERROR;
                        end else phase_next = PH_FMT;
                    end
                    PH_FMT: begin
                        if (v > 32'd2) begin
                            rows[0].kind = KIND_ERR; rows[0].error_code = ERR_FMT;
                            n = 2'd1; phase_next = PH_ERROR;
                        end else begin
                            fmt_next = v[1:0]; phase_next = PH_NTRK;
                        end
                    end
                    PH_NTRK: begin
                        ntrk_next = v[15:0]; phase_next = PH_DIV;
                    end
                    PH_DIV: begin
                        div_next = v[15:0];
                        rows[0].kind = KIND_HDR; rows[0].file_format = fmt_next;
                        rows[0].track_count = ntrk_next; rows[0].division = v[15:0];
                        n = 2'd1;
                        tcnt_next = '0;
                        phase_next = (ntrk_next == 16'd0) ? PH_DONE : PH_SIG_TRK;
                    end
                    PH_SIG_TRK: begin
                        if (v != SIG_MTRK) begin
                            rows[0].kind = KIND_ERR; rows[0].error_code = ERR_MTRK;
                            n = 2'd1; phase_next = PH_ERROR;
                        end else phase_next = PH_TRK_LEN;
                    end
                    default: begin
                        tleft_next = v; rs_next = '0; tacc_next = '0; cs_next = '0;
                        phase_next = PH_DELTA; dacc_next = '0;
                        if (v == 32'd0) begin
                            rows[0].kind = KIND_END; rows[0].track_index = tcnt_next;
                            n = 2'd1; ended = 1'b1;
                        end
                    end
                endcase
            end
        end else if (phase_next >= PH_DELTA && phase_next <= PH_CHAN) begin
            tleft_next = tleft_next - 32'd1;
            // A data byte where a status is due goes through the status step first,
            // then once more through the phase that the status leads to.
            if (phase_next == PH_STATUS) begin
                redo = ~b[7];
                if (b[7]) rs_next = b;
                st = rs_next;
                cs_next = st;
                if (st == ST_META) phase_next = PH_META_TYPE;
                else if (st == ST_SYSEX || st == ST_ESC) begin
                    phase_next = PH_BODY_LEN; bleft_next = '0;
                end else begin
                    cnt = data_count(st);
                    rows[0] = msg_row(tcnt_next, dacc_next, tacc_next, st, 1'b1,
                                      cnt == 2'd0);
                    n = 2'd1;
                    if (cnt == 2'd0) begin
                        phase_next = PH_DELTA; dacc_next = '0;
                    end else begin
                        bleft_next = {30'd0, cnt}; phase_next = PH_CHAN;
                    end
                end
            end else redo = 1'b1;
            if (redo) begin
                case (phase_next)
                    PH_DELTA: begin
                        dacc_next = {dacc_next[24:0], b[6:0]};
                        if (!b[7]) begin
                            tacc_next = tacc_next + dacc_next;
                            phase_next = PH_STATUS;
                        end
                    end
                    PH_META_TYPE: begin
                        mt_next = b; phase_next = PH_BODY_LEN; bleft_next = '0;
                    end
                    PH_BODY_LEN: begin
                        bl = {bleft_next[24:0], b[6:0]};
                        bleft_next = bl;
                        if (!b[7]) begin
                            if (cs_next == ST_META) begin
                                rows[0] = msg_row(tcnt_next, dacc_next, tacc_next,
                                                  ST_META, 1'b1, 1'b0);
                                rows[1] = msg_row(tcnt_next, dacc_next, tacc_next,
                                                  mt_next, 1'b0, bl == 32'd0);
                                n = 2'd2;
                            end else begin
                                rows[0] = msg_row(tcnt_next, dacc_next, tacc_next,
                                                  cs_next, 1'b1, bl == 32'd0);
                                n = 2'd1;
                            end
                            if (bl == 32'd0) begin
                                phase_next = PH_DELTA; dacc_next = '0;
                            end else phase_next = PH_BODY;
                        end
                    end
                    PH_BODY, PH_CHAN: begin
                        rows[n] = msg_row(tcnt_next, dacc_next, tacc_next, b, 1'b0,
                                          bleft_next == 32'd1);
                        n = n + 2'd1;
                        bleft_next = bleft_next - 32'd1;
                        if (bleft_next == 32'd0) begin
                            phase_next = PH_DELTA; dacc_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (tleft_next == 32'd0) begin
                if (n != 2'd0) rows[n - 2'd1].message_last = 1'b1;
                rows[n] = '0;
                rows[n].kind = KIND_END;
                rows[n].track_index = tcnt_next;
                rows[n].absolute_time = tacc_next;
                n = n + 2'd1;
                ended = 1'b1;
            end
        end

        if (ended) begin
            if (n == 2'd1) rows[0].absolute_time = tacc_next;
            tcnt_next = tcnt_next + 16'd1;
            phase_next = (tcnt_next == ntrk_next) ? PH_DONE : PH_SIG_TRK;
            fcnt_next = '0;
            facc_next = '0;
        end
        res.count = n;
        res.r0 = rows[0];
        res.r1 = rows[1];
        res.r2 = rows[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG_HDR; fcnt_reg <= '0; facc_reg <= '0; fmt_reg <= '0;
            ntrk_reg <= '0; div_reg <= '0; tcnt_reg <= '0; tleft_reg <= '0;
            dacc_reg <= '0; tacc_reg <= '0; rs_reg <= '0; cs_reg <= '0;
            mt_reg <= '0; bleft_reg <= '0;
        end else if (in_valid) begin
            phase_reg <= phase_next; fcnt_reg <= fcnt_next; facc_reg <= facc_next;
            fmt_reg <= fmt_next; ntrk_reg <= ntrk_next; div_reg <= div_next;
            tcnt_reg <= tcnt_next; tleft_reg <= tleft_next; dacc_reg <= dacc_next;
            tacc_reg <= tacc_next; rs_reg <= rs_next; cs_reg <= cs_next;
            mt_reg <= mt_next; bleft_reg <= bleft_next;
        end
    end

endmodule

// ----- rtl/mfep_out_buf.sv -----
// Result buffer: holds up to three rows of one byte and drains them one a cycle while m_ready is high.
// Depends on mfep_pkg.
`timescale 1ns / 1ps
module mfep_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  mfep_pkg::res_group_t res,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mfep_pkg::out_item_t  m_data
);
    import mfep_pkg::*;

    out_item_t  row_reg [MaxRes];
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;

    logic last_pop;
    assign m_valid  = cnt_reg != 2'd0;
    assign m_data   = row_reg[rd_reg];
    assign last_pop = m_valid && m_ready && (cnt_reg == 2'd1);
    assign can_load = !m_valid || last_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= res.count;
            rd_reg  <= '0;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg[0] <= res.r0;
            row_reg[1] <= res.r1;
            row_reg[2] <= res.r2;
        end
    end

endmodule

// ----- rtl/midi_file_event_parser_top.sv -----
// Standard MIDI file parser, one byte per request.
// Latency: a result row is valid the cycle after its byte is taken.
// Throughput: one byte per cycle while each byte yields at most one row and m_ready
// is high; a byte that yields two or three rows holds the input until the result
// buffer has drained its rows, one row per cycle while m_ready is high.
// Reset: aresetn (synchronous, active low) returns to header search, buffer empty.
`timescale 1ns / 1ps
module midi_file_event_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mfep_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mfep_pkg::out_item_t m_data
);
    import mfep_pkg::*;

    res_group_t res;
    logic       take;

    // Accept a byte whenever the buffer is empty or its last row leaves now.
    assign take = s_valid && s_ready;

    mfep_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(take),
        .in_item (s_data),
        .res     (res)
    );

    mfep_out_buf u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take),
        .res     (res),
        .can_load(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Input is held off while rows are pending beyond the one leaving.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");
    // A row shown that is not a message carries no message flags.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind != KIND_MSG) |-> (!m_data.message_first && !m_data.message_last))
        else $error("message flags on non-message row");

endmodule

// ----- bench/tb_midi_file_event_parser_top.sv -----
// Testbench for midi_file_event_parser_top: drives MIDI file byte streams and checks
// every result row against a behavioral parser held in a scoreboard class.
// Depends on mfep_pkg and the RTL of midi_file_event_parser_top.
`timescale 1ns / 1ps
module tb_midi_file_event_parser_top;
    import mfep_pkg::*;

    // Behavioral parser plus queue of pending result rows.
    class smf_scoreboard;
        logic [3:0]  phase;
        logic [2:0]  fcnt;
        logic [31:0] facc;
        logic [1:0]  fmt;
        logic [15:0] ntrk;
        logic [15:0] divn;
        logic [15:0] trk;
        logic [31:0] trk_left;
        logic [31:0] dacc;
        logic [31:0] tacc;
        logic [7:0]  rstat;
        logic [7:0]  cstat;
        logic [7:0]  mtype;
        logic [31:0] body_left;
        out_item_t   pending_rows[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_SIG_HDR; fcnt = '0; facc = '0; fmt = '0; ntrk = '0; divn = '0;
            trk = '0; trk_left = '0; dacc = '0; tacc = '0; rstat = '0; cstat = '0;
            mtype = '0; body_left = '0;
        endfunction

        function void push(logic [1:0] k, logic [15:0] ti, logic [31:0] dt,
                           logic [31:0] at, logic [7:0] mb, logic f, logic l,
                           logic [1:0] ff, logic [15:0] tc, logic [15:0] dv,
                           logic [1:0] ec);
            out_item_t r;
            r.kind = k; r.track_index = ti; r.delta_time = dt; r.absolute_time = at;
            r.message_byte = mb; r.message_first = f; r.message_last = l;
            r.file_format = ff; r.track_count = tc; r.division = dv; r.error_code = ec;
            pending_rows = {pending_rows, r};
        endfunction

        function void msg(logic [7:0] b, logic f, logic l);
            push(KIND_MSG, trk, dacc, tacc, b, f, l, '0, '0, '0, '0);
        endfunction

        function void fail(logic [1:0] code);
            push(KIND_ERR, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, code);
            phase = PH_ERROR;
        endfunction

        function void next_event();
            phase = PH_DELTA;
            dacc = '0;
        endfunction

        function int operands(logic [7:0] st);
            case (st[7:4])
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
                4'hC, 4'hD:                   return 1;
                default:                      return 0;
            endcase
        endfunction

        // Close the track; mark a message byte from this same request as last.
        function void close_track(int base);
            if (pending_rows.size() > base &&
                pending_rows[pending_rows.size()-1].kind == KIND_MSG)
                pending_rows[pending_rows.size()-1].message_last = 1'b1;
            push(KIND_END, trk, '0, tacc, '0, 1'b0, 1'b0, '0, '0, '0, '0);
            trk = trk + 16'd1;
            phase = (trk == ntrk) ? PH_DONE : PH_SIG_TRK;
            fcnt = '0;
            facc = '0;
        endfunction

        function void track_byte(logic [7:0] b);
            bit again;
            bit is_status;
            int cnt;
            again = 1;
            while (again) begin
                again = 0;
                case (phase)
                    PH_DELTA: begin
                        dacc = {dacc[24:0], b[6:0]};
                        if (!b[7]) begin
                            tacc = tacc + dacc;
                            phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        is_status = b[7];
                        if (is_status) rstat = b;
                        cstat = rstat;
                        if (rstat == ST_META) phase = PH_META_TYPE;
                        else if (rstat == ST_SYSEX || rstat == ST_ESC) begin
                            phase = PH_BODY_LEN;
                            body_left = '0;
                        end else begin
                            cnt = operands(rstat);
                            if (cnt == 0) begin
                                msg(rstat, 1'b1, 1'b1);
                                next_event();
                            end else begin
                                msg(rstat, 1'b1, 1'b0);
                                body_left = cnt;
                                phase = PH_CHAN;
                            end
                        end
                        if (!is_status) again = 1;
                    end
                    PH_META_TYPE: begin
                        mtype = b;
                        phase = PH_BODY_LEN;
                        body_left = '0;
                    end
                    PH_BODY_LEN: begin
                        body_left = {body_left[24:0], b[6:0]};
                        if (!b[7]) begin
                            if (cstat == ST_META) begin
                                msg(ST_META, 1'b1, 1'b0);
                                msg(mtype, 1'b0, body_left == 32'd0);
                            end else msg(cstat, 1'b1, body_left == 32'd0);
                            if (body_left == 32'd0) next_event();
                            else phase = PH_BODY;
                        end
                    end
                    PH_BODY, PH_CHAN: begin
                        msg(b, 1'b0, body_left == 32'd1);
                        body_left = body_left - 32'd1;
                        if (body_left == 32'd0) next_event();
                    end
                    default: ;
                endcase
            end
        endfunction

        // Note an accepted request and queue the rows it causes.
        function void note_request(in_item_t it);
            int need;
            int base;
            logic [31:0] v;
            base = pending_rows.size();
            if (it.start_of_file) clear();
            case (phase)
                PH_SIG_HDR, PH_HDR_LEN, PH_SIG_TRK, PH_TRK_LEN: need = 4;
                PH_FMT, PH_NTRK, PH_DIV:                        need = 2;
                default:                                        need = 0;
            endcase
            if (need != 0) begin
                facc = {facc[23:0], it.data_byte};
                fcnt = fcnt + 3'd1;
                if (fcnt < need) return;
                v = facc;
                fcnt = '0;
                facc = '0;
                case (phase)
                    PH_SIG_HDR: if (v != SIG_MTHD) fail(ERR_MTHD); else phase = PH_HDR_LEN;
                    PH_HDR_LEN: if (v != 32'd6) fail(ERR_HLEN); else phase = PH_FMT;
                    PH_FMT: if (v > 32'd2) fail(ERR_FMT);
                            else begin fmt = v[1:0]; phase = PH_NTRK; end
                    PH_NTRK: begin ntrk = v[15:0]; phase = PH_DIV; end
                    PH_DIV: begin
                        divn = v[15:0];
                        push(KIND_HDR, '0, '0, '0, '0, 1'b0, 1'b0, fmt, ntrk, divn, '0);
                        trk = '0;
                        phase = (ntrk == 16'd0) ? PH_DONE : PH_SIG_TRK;
                    end
                    PH_SIG_TRK: if (v != SIG_MTRK) fail(ERR_MTRK); else phase = PH_TRK_LEN;
                    default: begin
                        trk_left = v;
                        rstat = '0;
                        tacc = '0;
                        cstat = '0;
                        next_event();
                        if (v == 32'd0) close_track(base);
                    end
                endcase
                return;
            end
            if (phase >= PH_DELTA && phase <= PH_CHAN) begin
                trk_left = trk_left - 32'd1;
                track_byte(it.data_byte);
                if (trk_left == 32'd0) close_track(base);
            end
        endfunction

        function void check_row(out_item_t got);
            out_item_t want;
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            if (got !== want) begin
                $display("%0t: row mismatch expected %h actual %h", $realtime, want, got);
                if (got.kind !== want.kind)
                    $display("  kind expected %0d actual %0d", want.kind, got.kind);
                if (got.message_byte !== want.message_byte)
                    $display("  byte expected %h actual %h", want.message_byte,
                             got.message_byte);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    smf_scoreboard sb;
    bit  calm;          // true during the stretch with no idling
    byte unsigned file_bytes[$];
    bit  file_start[$];

    midi_file_event_parser_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Note accepted requests and check rows at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_row(m_data);
        end
    end

    // Stall the result side at random, except in the calm stretch.
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    end

    // Queue one byte; the first byte of a file carries start_of_file.
    task automatic add_byte(input byte unsigned b, input bit sof = 0);
        file_bytes = {file_bytes, b};
        file_start = {file_start, sof};
    endtask

    task automatic add_word(input logic [31:0] w, input int n);
        for (int i = n - 1; i >= 0; i--) add_byte(w[8*i +: 8]);
    endtask

    task automatic add_header(input logic [15:0] f, input logic [15:0] nt,
                              input logic [15:0] dv);
        add_byte(8'h4D, 1);
        add_word(SIG_MTHD, 3);
        add_word(32'd6, 4);
        add_word({16'd0, f}, 2);
        add_word({16'd0, nt}, 2);
        add_word({16'd0, dv}, 2);
    endtask

    // Drain the byte queue: send each byte, with random idle gaps.
    task automatic send_all();
        bit idle;
        while (file_bytes.size() > 0) begin
            idle = !calm && ($urandom_range(99) < 30);
            if (idle) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data.data_byte     <= file_bytes.pop_front();
                s_data.start_of_file <= file_start.pop_front();
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
            end
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Build a random track body of a handful of events, some cut off.
    task automatic add_random_track();
        byte unsigned body[$];
        int nev;
        int len;
        byte unsigned st;
        nev = $urandom_range(1, 6);
        for (int e = 0; e < nev; e++) begin
            case ($urandom_range(3))
                0: body = {body, 8'($urandom_range(127))};
                1: body = {body, 8'h81, 8'($urandom_range(127))};
                2: body = {body, 8'hFF, 8'h8F, 8'hFF, 8'($urandom_range(127))};
                default: body = {body, 8'h00};
            endcase
            case ($urandom_range(5))
                0, 1: begin
                    st = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
                    body = {body, st};
                    repeat (sb.operands(st)) body = {body, 8'($urandom)};
                end
                2: begin
                    body = {body, 8'hFF, 8'($urandom)};
                    len = $urandom_range(0, 3);
                    body = {body, 8'(len)};
                    repeat (len) body = {body, 8'($urandom)};
                end
                3: begin
                    body = {body, ($urandom_range(0, 1) != 0) ? 8'hF0 : 8'hF7};
                    len = $urandom_range(0, 2);
                    body = {body, 8'(len)};
                    repeat (len) body = {body, 8'($urandom)};
                end
                4: body = {body, 8'($urandom_range(8'hF1, 8'hFE))};
                default: repeat ($urandom_range(1, 2)) body = {body, 8'($urandom)};
            endcase
        end
        len = body.size();
        if ($urandom_range(9) == 0) len = $urandom_range(0, len);
        add_word(SIG_MTRK, 4);
        add_word(len, 4);
        for (int i = 0; i < len; i++) add_byte(body[i]);
    endtask

    int sent;

    initial begin
        sb = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: header extremes, running status, meta, sysex, long delta.
        add_header(16'd2, 16'd2, 16'hFFFF);
        add_word(SIG_MTRK, 4);
        add_word(32'd20, 4);
        add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'h7F); add_byte(8'h90); add_byte(8'hFF); add_byte(8'h80);
        add_byte(8'h00); add_byte(8'h40); add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'h2F); add_byte(8'h00); add_byte(8'h00); add_byte(8'hF0);
        add_byte(8'h01); add_byte(8'hF7); add_byte(8'h00); add_byte(8'hC5);
        add_word(SIG_MTRK, 4);
        add_word(32'd0, 4);
        add_byte(8'hAA);
        sent += file_bytes.size();
        send_all();
        add_header(16'd0, 16'd0, 16'd0);
        add_byte(8'h00, 1); add_word(32'h00FFFFFF, 3);
        add_header(16'd3, 16'd1, 16'd1);
        add_byte(8'h4D, 1); add_word(SIG_MTHD, 3); add_word(32'd7, 4);
        add_header(16'd1, 16'd1, 16'd96);
        add_word(32'h4D54726A, 4);
        sent += file_bytes.size();
        send_all();

        // Random files; a calm stretch in the middle.
        while (sent < 240) begin
            calm = (sent > 130 && sent < 190);
            if ($urandom_range(9) == 0) begin
                add_byte(8'($urandom), 1);
                repeat ($urandom_range(1, 15)) add_byte(8'($urandom));
            end else begin
                add_header(16'($urandom_range(0, 2)), 16'($urandom_range(1, 3)),
                           16'($urandom));
                repeat ($urandom_range(1, 3)) add_random_track();
            end
            sent += file_bytes.size();
            send_all();
        end
        calm = 1'b0;

        while (sb.pending_rows.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
